@@ hw/rtl/lidar_window_obstacle_midpoint_macros.svh @@
// Assertion macros shared by the lidar window obstacle midpoint RTL.
`ifndef LIDAR_WINDOW_OBSTACLE_MIDPOINT_MACROS_SVH
`define LIDAR_WINDOW_OBSTACLE_MIDPOINT_MACROS_SVH

// Check that the consequent holds in the same cycle as the antecedent.
`define LWOM_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error(msg);

// Check that the consequent holds in the cycle after the antecedent.
`define LWOM_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

@@ hw/rtl/lwom_pkg.sv @@
// Types, constants and sine table function for the lidar window obstacle midpoint block.
package lwom_pkg;

	// Sequencer states
	typedef enum logic [2:0] {
		ST_IDLE,
		ST_ANGLE,
		ST_INDEX,
		ST_SINE,
		ST_MUL,
		ST_EMIT
	} lwom_state_t;

	// Configuration register indexes
	localparam logic [1:0] CFG_THRESHOLD   = 2'd0;
	localparam logic [1:0] CFG_ANGLE_START = 2'd1;
	localparam logic [1:0] CFG_ANGLE_STEP  = 2'd2;

	localparam logic [15:0] THRESHOLD_RESET   = 16'd600;
	localparam logic [15:0] ANGLE_START_RESET = 16'd0;
	localparam logic [15:0] ANGLE_STEP_RESET  = 16'd182;

	// Beams at or beyond this index never count as obstacle
	localparam logic [12:0] MAX_BEAMS = 13'd1024;

	localparam logic [63:0] Q30_ONE     = 64'h0000_0000_4000_0000;
	localparam logic [63:0] HALF_PI_Q30 = 64'd1686629713;

	// Unsigned Q0.15 sine magnitude for a table position t (Q30 fraction of a quarter wave).
	// Used at elaboration only.
	function automatic logic [14:0] sine_q15_entry(input logic [63:0] t);
		logic [63:0] x;
		logic [63:0] x2;
		logic [63:0] f;
		logic [63:0] s;
		logic [63:0] q;
		x = (t * HALF_PI_Q30) >> 30;
		x2 = (x * x) >> 30;
		f = Q30_ONE;
		f = Q30_ONE - (((x2 * f) >> 30) / 64'd110);
		f = Q30_ONE - (((x2 * f) >> 30) / 64'd72);
		f = Q30_ONE - (((x2 * f) >> 30) / 64'd42);
		f = Q30_ONE - (((x2 * f) >> 30) / 64'd20);
		f = Q30_ONE - (((x2 * f) >> 30) / 64'd6);
		s = (x * f) >> 30;
		q = (s + 64'd16384) >> 15;
		if (q > 64'd32767) begin
			q = 64'd32767;
		end
		return q[14:0];
	endfunction

endpackage

@@ hw/rtl/lwom_sine_rom.sv @@
// Quarter-wave unsigned Q0.15 sine table with registered read.
module lwom_sine_rom #(
	parameter int ENTRIES = 1024
) (
	input  logic                             clk,
	input  logic                             rd_en,
	input  logic [$clog2(ENTRIES + 1) - 1:0] idx,
	output logic [14:0]                      data
);

	localparam int DEPTH = ENTRIES + 1;

	logic [14:0] rom_w [DEPTH];
	logic [14:0] data_q;

	// Build table contents at elaboration
	for (genvar k = 0; k < DEPTH; k++) begin : g_tab
		localparam logic [63:0] TK = (64'(k) << 30) / 64'(ENTRIES);
		assign rom_w[k] = lwom_pkg::sine_q15_entry(TK);
	end

	always_ff @(posedge clk) begin
		if (rd_en) begin
			data_q <= rom_w[idx];
		end
	end

	assign data = data_q;

endmodule

@@ hw/rtl/lidar_window_obstacle_midpoint.sv @@
// Lidar window obstacle midpoint: top level with sequencer, shared multiplier and output word.
// Sequence: after accept an obstacle sample runs the angle, index, table read and range product
// states; other samples need none; a window end adds an emit state to load the output word.
// Throughput: input is taken only in idle; obstacle samples hold off the next, set by the single
// 16x16 multiplier used three times in turn plus the registered sine table read; so do emits.
// Reset: asynchronous, clears sequencer, configuration, window state and output valid.
`include "lidar_window_obstacle_midpoint_macros.svh"

module lidar_window_obstacle_midpoint #(
	parameter int SINE_ENTRIES = 1024
) (
	input  logic               clk,
	input  logic               arst_n,
	// input sample words
	input  logic               in_valid,
	output logic               in_stall,
	input  logic [15:0]        range_mm,
	input  logic [9:0]         beam_index,
	input  logic               window_end,
	// result words
	output logic               out_valid,
	input  logic               out_stall,
	output logic signed [16:0] midpoint_mm,
	output logic               found,
	// configuration writes
	input  logic               cfg_valid,
	output logic               cfg_ready,
	input  logic [1:0]         cfg_index,
	input  logic [15:0]        cfg_data
);

	localparam int IDX_W = $clog2(SINE_ENTRIES + 1);

	lwom_pkg::lwom_state_t state_q, state_d;

	// Configuration registers
	logic [15:0]        threshold_q;
	logic signed [15:0] angle_start_q;
	logic [15:0]        angle_step_q;

	// Captured sample
	logic [15:0] range_q;
	logic [9:0]  beam_q;
	logic        end_q;

	// Working registers
	logic [15:0]      angle_q;
	logic [IDX_W-1:0] idx_q;
	logic [14:0]      sine_w;

	// Window state
	logic               seen_q;
	logic signed [16:0] first_y_q;
	logic signed [16:0] last_y_q;

	// Output word
	logic               out_valid_q;
	logic signed [16:0] midpoint_q;
	logic               found_q;

	// Sequencer outputs
	logic        in_acc;
	logic        obstacle_w;
	logic        rom_rd;
	logic        load_out;
	logic        out_free;
	logic [15:0] mul_a;
	logic [15:0] mul_b;
	logic [31:0] mul_p;

	// Datapath intermediates
	logic [1:0]         quad_w;
	logic [14:0]        pos_w;
	logic [15:0]        y_mag_w;
	logic signed [16:0] y_w;
	logic signed [17:0] sum_w;
	logic [17:0]        sum_mag_w;
	logic [16:0]        half_w;
	logic signed [16:0] mid_w;

	assign in_acc     = in_valid && !in_stall;
	assign obstacle_w = (13'(beam_index) < lwom_pkg::MAX_BEAMS) && (range_mm < threshold_q);
	assign out_free   = !out_valid_q || !out_stall;

	// Configuration port: always ready; the host must write only while no sample is in flight; not enforced
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			threshold_q   <= lwom_pkg::THRESHOLD_RESET;
			angle_start_q <= lwom_pkg::ANGLE_START_RESET;
			angle_step_q  <= lwom_pkg::ANGLE_STEP_RESET;
		end else if (cfg_valid && cfg_ready) begin
			unique case (cfg_index)
				lwom_pkg::CFG_THRESHOLD:   threshold_q   <= cfg_data;
				lwom_pkg::CFG_ANGLE_START: angle_start_q <= cfg_data;
				lwom_pkg::CFG_ANGLE_STEP:  angle_step_q  <= cfg_data;
				default: begin
					// unknown register index: drop the write
				end
			endcase
		end
	end

	// Next-state logic
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			lwom_pkg::ST_IDLE: begin
				if (in_acc) begin
					if (obstacle_w) begin
						state_d = lwom_pkg::ST_ANGLE;
					end else if (window_end) begin
						state_d = lwom_pkg::ST_EMIT;
					end
				end
			end
			lwom_pkg::ST_ANGLE: state_d = lwom_pkg::ST_INDEX;
			lwom_pkg::ST_INDEX: state_d = lwom_pkg::ST_SINE;
			lwom_pkg::ST_SINE:  state_d = lwom_pkg::ST_MUL;
			lwom_pkg::ST_MUL: begin
				state_d = end_q ? lwom_pkg::ST_EMIT : lwom_pkg::ST_IDLE;
			end
			lwom_pkg::ST_EMIT: begin
				if (out_free) begin
					state_d = lwom_pkg::ST_IDLE;
				end
			end
			default: state_d = lwom_pkg::ST_IDLE;
		endcase
	end

	// Quadrant fold of the angle into a quarter-wave position
	assign quad_w = angle_q[15:14];
	assign pos_w  = quad_w[0] ? (15'd16384 - {1'b0, angle_q[13:0]}) : {1'b0, angle_q[13:0]};

	// Sequencer outputs: steer the shared multiplier and the table read
	always_comb begin
		in_stall = 1'b1;
		rom_rd   = 1'b0;
		load_out = 1'b0;
		mul_a    = '0;
		mul_b    = '0;
		unique case (state_q)
			lwom_pkg::ST_IDLE: in_stall = 1'b0;
			lwom_pkg::ST_ANGLE: begin
				// step times beam index
				mul_a = angle_step_q;
				mul_b = 16'(beam_q);
			end
			lwom_pkg::ST_INDEX: begin
				// scale position to table index
				mul_a = 16'(pos_w);
				mul_b = 16'(SINE_ENTRIES);
			end
			lwom_pkg::ST_SINE: rom_rd = 1'b1;
			lwom_pkg::ST_MUL: begin
				// range times sine magnitude
				mul_a = range_q;
				mul_b = 16'(sine_w);
			end
			lwom_pkg::ST_EMIT: load_out = out_free;
			default: begin
			end
		endcase
	end

	// The one shared multiplier
	assign mul_p = mul_a * mul_b;

	lwom_sine_rom #(
		.ENTRIES(SINE_ENTRIES)
	) u_sine_rom (
		.clk  (clk),
		.rd_en(rom_rd),
		.idx  (idx_q),
		.data (sine_w)
	);

	// Lateral y: round half away from zero, sign from the lower half-wave
	assign y_mag_w = 16'((mul_p + 32'd16384) >> 15);
	assign y_w     = angle_q[15] ? -$signed(17'(y_mag_w)) : $signed(17'(y_mag_w));

	// Midpoint: mean of first and last y, ties away from zero
	assign sum_w     = 18'(first_y_q) + 18'(last_y_q);
	assign sum_mag_w = sum_w[17] ? 18'(-sum_w) : 18'(sum_w);
	assign half_w    = 17'((sum_mag_w + 18'd1) >> 1);
	assign mid_w     = sum_w[17] ? -$signed(half_w) : $signed(half_w);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= lwom_pkg::ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// Sample capture and working registers
	always_ff @(posedge clk) begin
		if (in_acc) begin
			range_q <= range_mm;
			beam_q  <= beam_index;
			end_q   <= window_end;
		end
		if (state_q == lwom_pkg::ST_ANGLE) begin
			angle_q <= 16'(angle_start_q) + mul_p[15:0];
		end
		if (state_q == lwom_pkg::ST_INDEX) begin
			idx_q <= mul_p[14 +: IDX_W];
		end
	end

	// Window state: hold first y, advance last y, clear on emit
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			seen_q    <= 1'b0;
			first_y_q <= '0;
			last_y_q  <= '0;
		end else if (load_out) begin
			seen_q    <= 1'b0;
			first_y_q <= '0;
			last_y_q  <= '0;
		end else if (state_q == lwom_pkg::ST_MUL) begin
			if (!seen_q) begin
				first_y_q <= y_w;
			end
			seen_q   <= 1'b1;
			last_y_q <= y_w;
		end
	end

	// Output word: hold while stalled
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (load_out) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (load_out) begin
			midpoint_q <= seen_q ? mid_w : '0;
			found_q    <= seen_q;
		end
	end

	assign out_valid   = out_valid_q;
	assign midpoint_mm = midpoint_q;
	assign found       = found_q;

	`LWOM_ASSERT_NOW(a_no_obstacle_zero, clk, arst_n, out_valid_q && !found_q, midpoint_q == '0, "midpoint nonzero without obstacle")
	`LWOM_ASSERT_NEXT(a_emit_clears, clk, arst_n, load_out, !seen_q && first_y_q == '0 && last_y_q == '0, "window state not cleared after emit")
	`LWOM_ASSERT_NOW(a_seen_drop, clk, arst_n, $fell(seen_q), $past(state_q) == lwom_pkg::ST_EMIT, "window state dropped outside emit")
	`LWOM_ASSERT_NOW(a_idx_range, clk, arst_n, state_q == lwom_pkg::ST_SINE, idx_q <= IDX_W'(SINE_ENTRIES), "sine index beyond table")

endmodule

@@ verif/lwom_midpoint_checker.sv @@
// Checker for the lidar window obstacle midpoint block: predicts each window result and compares.
module lwom_midpoint_checker
	import lwom_pkg::*;
#(
	parameter int SINE_ENTRIES = 1024
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	input  logic               in_stall,
	input  logic [15:0]        range_mm,
	input  logic [9:0]         beam_index,
	input  logic               window_end,
	input  logic               out_valid,
	input  logic               out_stall,
	input  logic signed [16:0] midpoint_mm,
	input  logic               found,
	input  logic               cfg_valid,
	input  logic               cfg_ready,
	input  logic [1:0]         cfg_index,
	input  logic [15:0]        cfg_data,
	output int                 fail_count,
	output int                 pending,
	output int                 windows_done,
	output int                 windows_hit
);

	typedef struct packed {
		logic signed [16:0] midpoint;
		logic               found;
	} window_word_t;

	int sine_mag [0:SINE_ENTRIES];

	logic [15:0]        thr_q;
	logic [15:0]        start_q;
	logic [15:0]        step_q;
	logic               seen_q;
	logic signed [16:0] first_q;
	logic signed [16:0] last_q;

	window_word_t window_q [$];
	window_word_t want;
	logic signed [16:0] y_now;
	int fails;
	int done_n;
	int hit_n;
	int sum;
	int mag;
	int half;

	// Unsigned Q0.15 magnitude of sin(pi/2 * k / SINE_ENTRIES), Taylor series in Q30
	function automatic int quarter_sine(int k);
		longint unsigned divs [5] = '{110, 72, 42, 20, 6};
		longint unsigned one;
		longint unsigned kk;
		longint unsigned n;
		longint unsigned t;
		longint unsigned x;
		longint unsigned x2;
		longint unsigned f;
		longint unsigned s;
		longint unsigned q;
		one = 64'd1 << 30;
		kk = k;
		n = SINE_ENTRIES;
		t = (kk << 30) / n;
		x = (t * 64'd1686629713) >> 30;
		x2 = (x * x) >> 30;
		f = one;
		for (int i = 0; i < 5; i++) begin
			f = one - (((x2 * f) >> 30) / divs[i]);
		end
		s = (x * f) >> 30;
		q = (s + 64'd16384) >> 15;
		if (q > 64'd32767) begin
			q = 64'd32767;
		end
		return int'(q);
	endfunction

	// Lateral coordinate of one beam at the current angle settings
	function automatic logic signed [16:0] lateral_y(logic [15:0] rng, logic [9:0] beam);
		logic [15:0]        ang;
		logic [14:0]        pos;
		int                 idx;
		longint unsigned    prod;
		logic signed [16:0] y;
		ang = start_q + step_q * beam;
		pos = ang[14] ? 15'd16384 - {1'b0, ang[13:0]} : {1'b0, ang[13:0]};
		idx = (int'(pos) * SINE_ENTRIES) >> 14;
		if (idx > SINE_ENTRIES) begin
			idx = SINE_ENTRIES;
		end
		prod = rng;
		prod = (prod * longint'(sine_mag[idx]) + 64'd16384) >> 15;
		y = prod[16:0];
		return ang[15] ? -y : y;
	endfunction

	initial begin
		for (int k = 0; k <= SINE_ENTRIES; k++) begin
			sine_mag[k] = quarter_sine(k);
		end
	end

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			thr_q = THRESHOLD_RESET;
			start_q = ANGLE_START_RESET;
			step_q = ANGLE_STEP_RESET;
			seen_q = 1'b0;
			first_q = '0;
			last_q = '0;
			window_q.delete();
			fails = 0;
			done_n = 0;
			hit_n = 0;
		end else begin
			if (cfg_valid && cfg_ready) begin
				case (cfg_index)
					CFG_THRESHOLD: begin
						thr_q = cfg_data;
					end
					CFG_ANGLE_START: begin
						start_q = cfg_data;
					end
					CFG_ANGLE_STEP: begin
						step_q = cfg_data;
					end
					default: begin
					end
				endcase
			end

			// retire the oldest expectation before adding one from this edge
			if (out_valid && !out_stall) begin
				if (window_q.size() == 0) begin
					$error("result word with nothing expected: midpoint_mm %0d found %0d",
						midpoint_mm, found);
					fails++;
				end else begin
					want = window_q.pop_front();
					done_n++;
					if (found === 1'b1) begin
						hit_n++;
					end
					if (midpoint_mm !== want.midpoint) begin
						$error("midpoint_mm mismatch: expected %0d, actual %0d",
							want.midpoint, midpoint_mm);
						fails++;
					end
					if (found !== want.found) begin
						$error("found mismatch: expected %0d, actual %0d", want.found, found);
						fails++;
					end
				end
			end

			if (in_valid && !in_stall) begin
				if (beam_index < MAX_BEAMS && range_mm < thr_q) begin
					y_now = lateral_y(range_mm, beam_index);
					if (!seen_q) begin
						first_q = y_now;
						seen_q = 1'b1;
					end
					last_q = y_now;
				end
				if (window_end) begin
					want.midpoint = '0;
					want.found = seen_q;
					if (seen_q) begin
						sum = first_q + last_q;
						mag = (sum < 0) ? -sum : sum;
						half = (mag + 1) >> 1;
						want.midpoint = (sum < 0) ? -half : half;
					end
					// append at the tail of the expectation queue
					window_q = {window_q, want};
					seen_q = 1'b0;
					first_q = '0;
					last_q = '0;
				end
			end
		end
		fail_count <= fails;
		pending <= window_q.size();
		windows_done <= done_n;
		windows_hit <= hit_n;
	end

endmodule

@@ verif/tb_top.sv @@
// Top of the lidar window obstacle midpoint testbench: clock, reset, stimulus and verdict.
module tb_top;
	import lwom_pkg::*;

	localparam int SINE_N       = 1024;
	localparam int RANDOM_ITEMS = 950;
	localparam int PHASE_ITEMS  = 120;
	localparam int HOLD_CYCLES  = 300;
	// leave room for an obstacle sample's states and a window end's emit state to finish
	localparam int SETTLE       = 8;

	logic               clk = 1'b0;
	logic               arst_n;
	logic               in_valid;
	logic               in_stall;
	logic [15:0]        range_mm;
	logic [9:0]         beam_index;
	logic               window_end;
	logic               out_valid;
	logic               out_stall;
	logic signed [16:0] midpoint_mm;
	logic               found;
	logic               cfg_valid;
	logic               cfg_ready;
	logic [1:0]         cfg_index;
	logic [15:0]        cfg_data;

	int fail_count;
	int pending;
	int windows_done;
	int windows_hit;

	// stimulus bookkeeping
	int          sent = 0;
	int          settings = 0;
	int          hold_asked = 0;
	int          hold_taken = 0;
	logic        calm = 1'b0;
	logic        window_open = 1'b0;
	logic [15:0] thr_now = THRESHOLD_RESET;

	always #1 clk = ~clk;

	lidar_window_obstacle_midpoint #(
		.SINE_ENTRIES(SINE_N)
	) dut (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (in_valid),
		.in_stall   (in_stall),
		.range_mm   (range_mm),
		.beam_index (beam_index),
		.window_end (window_end),
		.out_valid  (out_valid),
		.out_stall  (out_stall),
		.midpoint_mm(midpoint_mm),
		.found      (found),
		.cfg_valid  (cfg_valid),
		.cfg_ready  (cfg_ready),
		.cfg_index  (cfg_index),
		.cfg_data   (cfg_data)
	);

	lwom_midpoint_checker #(
		.SINE_ENTRIES(SINE_N)
	) midpoint_check (
		.clk         (clk),
		.arst_n      (arst_n),
		.in_valid    (in_valid),
		.in_stall    (in_stall),
		.range_mm    (range_mm),
		.beam_index  (beam_index),
		.window_end  (window_end),
		.out_valid   (out_valid),
		.out_stall   (out_stall),
		.midpoint_mm (midpoint_mm),
		.found       (found),
		.cfg_valid   (cfg_valid),
		.cfg_ready   (cfg_ready),
		.cfg_index   (cfg_index),
		.cfg_data    (cfg_data),
		.fail_count  (fail_count),
		.pending     (pending),
		.windows_done(windows_done),
		.windows_hit (windows_hit)
	);

	// Idle length: mostly none or short, now and then a long one; none while calm.
	function automatic int idle_len();
		int pick;
		if (calm) begin
			return 0;
		end
		pick = $urandom_range(0, 99);
		if (pick < 55) begin
			return 0;
		end else if (pick < 90) begin
			return $urandom_range(1, 3);
		end else if (pick < 97) begin
			return $urandom_range(4, 10);
		end
		return $urandom_range(20, 60);
	endfunction

	// Range drawn around the current threshold so both sides of it get hit often.
	function automatic logic [15:0] pick_range();
		int pick;
		pick = $urandom_range(0, 9);
		if (thr_now == 16'd0 || pick >= 7) begin
			return 16'($urandom_range(0, 65535));
		end else if (pick < 5) begin
			return 16'($urandom_range(0, thr_now - 1));
		end else if (pick == 5) begin
			return thr_now - 16'd1;
		end
		return thr_now;
	endfunction

	// Offer one sample word and hold it until the block takes it.
	task automatic send_sample(logic [15:0] rng, logic [9:0] beam, logic last);
		in_valid <= 1'b1;
		range_mm <= rng;
		beam_index <= beam;
		window_end <= last;
		@(posedge clk);
		while (in_stall) begin
			@(posedge clk);
		end
		sent++;
		window_open = !last;
	endtask

	// Drop valid for a random gap; with no gap the next word follows at once.
	task automatic idle_sender();
		int gap;
		gap = idle_len();
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
	endtask

	// Hold until every predicted window result has come out.
	task automatic wait_results();
		do begin
			@(posedge clk);
		end while (pending != 0);
	endtask

	// Close the stream and let the block go fully idle.
	task automatic drain();
		in_valid <= 1'b0;
		wait_results();
		repeat (SETTLE) @(posedge clk);
	endtask

	task automatic write_reg(logic [1:0] idx, logic [15:0] value);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= value;
		@(posedge clk);
		while (!cfg_ready) begin
			@(posedge clk);
		end
	endtask

	// Write all three registers back to back; only call while the block is idle.
	task automatic set_config(logic [15:0] thr, logic [15:0] start, logic [15:0] step);
		write_reg(CFG_THRESHOLD, thr);
		write_reg(CFG_ANGLE_START, start);
		write_reg(CFG_ANGLE_STEP, step);
		cfg_valid <= 1'b0;
		thr_now = thr;
		settings++;
	endtask

	// One scan window: mostly ordered beams ending on a mark, sometimes a broken
	// run with scattered beams and marks anywhere.
	task automatic send_window();
		int   len;
		int   beam;
		logic ordered;
		logic last;
		ordered = ($urandom_range(0, 9) < 8);
		len = ($urandom_range(0, 9) == 0) ? $urandom_range(13, 40) : $urandom_range(1, 12);
		beam = $urandom_range(0, 1023);
		for (int i = 0; i < len; i++) begin
			if (ordered) begin
				beam = (beam + $urandom_range(1, 3)) % 1024;
				last = (i == len - 1);
			end else begin
				beam = $urandom_range(0, 1023);
				last = ($urandom_range(0, 5) == 0);
			end
			send_sample(pick_range(), 10'(beam), last);
			idle_sender();
		end
	endtask

	// Receiver: alternate free and stalled runs; serve a long hold-off when asked,
	// and never stall while calm.
	initial begin
		int   run;
		logic stall_now;
		stall_now = 1'b0;
		out_stall <= 1'b0;
		wait (arst_n === 1'b1);
		forever begin
			if (hold_taken != hold_asked) begin
				hold_taken = hold_asked;
				stall_now = 1'b1;
				run = HOLD_CYCLES;
			end else if (calm) begin
				stall_now = 1'b0;
				run = 1;
			end else begin
				stall_now = !stall_now;
				run = stall_now ? idle_len() + 1 : $urandom_range(1, 7);
			end
			out_stall <= stall_now;
			repeat (run) @(posedge clk);
		end
	end

	// Main stimulus
	initial begin
		int start_items;
		int phase;
		arst_n <= 1'b0;
		in_valid <= 1'b0;
		range_mm <= '0;
		beam_index <= '0;
		window_end <= 1'b0;
		cfg_valid <= 1'b0;
		cfg_index <= CFG_THRESHOLD;
		cfg_data <= '0;
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// reset settings: range equal to threshold is no obstacle
		send_sample(16'd600, 10'd0, 1'b1);
		idle_sender();
		// single obstacle point: first and last are the same
		send_sample(16'd599, 10'd90, 1'b1);
		idle_sender();
		// first and latest obstacle with a far sample in between, extremes of beam
		send_sample(16'd0, 10'd1023, 1'b0);
		send_sample(16'd599, 10'd360, 1'b0);
		send_sample(16'hFFFF, 10'd500, 1'b0);
		send_sample(16'd300, 10'd200, 1'b1);
		idle_sender();
		// window with nothing near
		send_sample(16'hFFFF, 10'd1023, 1'b1);
		drain();

		// zero threshold: even a zero range is not an obstacle
		set_config(16'd0, 16'd0, ANGLE_STEP_RESET);
		send_sample(16'd0, 10'd0, 1'b1);
		drain();

		// widest threshold, most negative start, largest step: angles wrap
		set_config(16'hFFFF, 16'h8000, 16'hFFFF);
		send_sample(16'd65534, 10'd1023, 1'b0);
		send_sample(16'd1, 10'd0, 1'b0);
		send_sample(16'd40000, 10'd1, 1'b1);
		drain();

		// quarter-wave steps: each quadrant edge, then a wrap past a full turn
		set_config(16'hFFFF, 16'd0, 16'd16384);
		send_sample(16'd65534, 10'd1, 1'b1);
		send_sample(16'd65534, 10'd2, 1'b1);
		send_sample(16'd65534, 10'd3, 1'b1);
		send_sample(16'd65534, 10'd5, 1'b1);
		// mixed signs, then two negative points for rounding away from zero
		send_sample(16'd60000, 10'd3, 1'b0);
		send_sample(16'd1000, 10'd1, 1'b1);
		send_sample(16'd60000, 10'd3, 1'b0);
		send_sample(16'd60001, 10'd7, 1'b1);
		drain();

		// random phases, each with its own settings
		phase = 0;
		start_items = sent;
		while (sent - start_items < RANDOM_ITEMS) begin
			case (phase % 8)
				0: begin
					set_config(16'hFFFF, 16'h8000, 16'hFFFF);
				end
				1: begin
					set_config(16'd1, 16'h7FFF, 16'd0);
				end
				4: begin
					set_config(THRESHOLD_RESET, ANGLE_START_RESET, ANGLE_STEP_RESET);
				end
				5: begin
					set_config(16'd0, 16'($urandom_range(0, 65535)),
						16'($urandom_range(0, 65535)));
				end
				default: begin
					set_config(($urandom_range(0, 3) == 0) ? 16'($urandom_range(1, 700)) :
						16'($urandom_range(0, 65535)), 16'($urandom_range(0, 65535)),
						16'($urandom_range(0, 65535)));
				end
			endcase
			// stall the output for a long stretch while words keep coming in
			if (phase == 3) begin
				hold_asked++;
			end
			// one phase runs without any idling on either side
			if (phase == 6) begin
				calm <= 1'b1;
			end
			begin
				int phase_start;
				phase_start = sent;
				while (sent - phase_start < PHASE_ITEMS &&
					sent - start_items < RANDOM_ITEMS) begin
					send_window();
					if ($urandom_range(0, 24) == 0) begin
						in_valid <= 1'b0;
						wait_results();
					end
				end
			end
			// close any window left open so the next settings start clean
			if (window_open) begin
				send_sample(pick_range(), 10'($urandom_range(0, 1023)), 1'b1);
			end
			drain();
			if (phase == 6) begin
				calm <= 1'b0;
			end
			phase++;
		end

		repeat (SETTLE) @(posedge clk);
		$display("run covered %0d samples over %0d register settings", sent, settings);
		$display("%0d windows checked, %0d of them with an obstacle", windows_done,
			windows_hit);
		if (fail_count == 0 && pending == 0) begin
			$display("simulation ok");
		end else begin
			$display("simulation failed");
		end
		$finish;
	end

	// Watchdog
	initial begin
		#2000000;
		$display("simulation failed");
		$finish;
	end

endmodule

@@ filelist.f @@
+incdir+hw/rtl
hw/rtl/lwom_pkg.sv
hw/rtl/lwom_sine_rom.sv
hw/rtl/lidar_window_obstacle_midpoint.sv
verif/lwom_midpoint_checker.sv
verif/tb_top.sv
